// ===== design/bps_pkg.sv =====
// ----------------------------------------------------------------------------
// Bouncing particle step: shared definitions
// Request and result layouts, particle store entry, register codes, reset
// values and the saturating velocity negation used by several modules.
// ----------------------------------------------------------------------------
package bps_pkg;

  localparam int SLOT_W     = 6;
  localparam int POS_W      = 20;
  localparam int VEL_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam int POS_MAX = 1048575;

  localparam logic signed [VEL_W-1:0] VEL_MAX = 16'sh7FFF;
  localparam logic signed [VEL_W-1:0] VEL_MIN = 16'sh8000;

  // Request kinds.
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT  = 2'd3;

  // Configuration reset values.
  localparam logic [7:0]  GRAVITY_RST = 8'd26;
  localparam logic [7:0]  RADIUS_RST  = 8'd5;
  localparam logic [11:0] WIDTH_RST   = 12'd800;
  localparam logic [11:0] HEIGHT_RST  = 12'd600;

  typedef struct packed {
    logic                    action;
    logic [SLOT_W-1:0]       slot;
    logic [POS_W-1:0]        load_x;
    logic [POS_W-1:0]        load_y;
    logic signed [VEL_W-1:0] load_vx;
    logic signed [VEL_W-1:0] load_vy;
  } bps_in_t;

  typedef struct packed {
    logic [SLOT_W-1:0]       out_slot;
    logic [POS_W-1:0]        out_x;
    logic [POS_W-1:0]        out_y;
    logic signed [VEL_W-1:0] out_vx;
    logic signed [VEL_W-1:0] out_vy;
    logic                    last;
  } bps_out_t;

  typedef struct packed {
    logic [POS_W-1:0]        x;
    logic [POS_W-1:0]        y;
    logic signed [VEL_W-1:0] vx;
    logic signed [VEL_W-1:0] vy;
  } bps_entry_t;

  // Negation that saturates, so the most negative value maps to the most positive.
  function automatic logic signed [VEL_W-1:0] neg_vel(input logic signed [VEL_W-1:0] v);
    neg_vel = (v == VEL_MIN) ? VEL_MAX : -v;
  endfunction

endpackage

// ===== design/bps_wall.sv =====
// ----------------------------------------------------------------------------
// Bouncing particle step: wall unit
// Applies the low and the high wall of one axis to a moved position, then
// saturates the position to the stored range.
// ----------------------------------------------------------------------------
module bps_wall #(
  parameter int AW = 22
) (
  input  logic signed [AW-1:0]               pos,
  input  logic signed [bps_pkg::VEL_W-1:0]   vel,
  input  logic signed [AW-1:0]               lo,
  input  logic signed [AW-1:0]               hi,
  output logic [bps_pkg::POS_W-1:0]          pos_o,
  output logic signed [bps_pkg::VEL_W-1:0]   vel_o
);

  localparam logic signed [AW-1:0] PMAX = AW'(bps_pkg::POS_MAX);

  logic signed [AW-1:0]             p1;
  logic signed [AW-1:0]             p2;
  logic signed [bps_pkg::VEL_W-1:0] v1;
  logic                             hit_lo;
  logic                             hit_hi;

  // The high wall sees the position already moved by the low wall.
  always_comb begin
    hit_lo = (pos <= lo);
    p1     = hit_lo ? lo : pos;
    v1     = hit_lo ? bps_pkg::neg_vel(vel) : vel;
    hit_hi = (p1 >= hi);
    p2     = hit_hi ? hi : p1;
    vel_o  = hit_hi ? bps_pkg::neg_vel(v1) : v1;
    if (p2 < 0) begin
      pos_o = '0;
    end else if (p2 > PMAX) begin
      pos_o = '1;
    end else begin
      pos_o = p2[bps_pkg::POS_W-1:0];
    end
  end

endmodule

// ===== design/bps_mem.sv =====
// ----------------------------------------------------------------------------
// Bouncing particle step: particle store
// One write port and one registered read port. Per-entry valid bits make an
// entry that was never written since reset read as zero.
// ----------------------------------------------------------------------------
module bps_mem #(
  parameter int DEPTH = 64,
  parameter int IW    = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                we,
  input  logic [IW-1:0]       waddr,
  input  bps_pkg::bps_entry_t wdata,
  input  logic                re,
  input  logic [IW-1:0]       raddr,
  output bps_pkg::bps_entry_t rdata
);

  bps_pkg::bps_entry_t mem [DEPTH];
  logic [DEPTH-1:0]    valid_r;
  bps_pkg::bps_entry_t rd_r;
  logic                rd_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (we) begin
      valid_r[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r <= 1'b0;
    end else if (re) begin
      rd_valid_r <= valid_r[raddr];
    end
  end

  assign rdata = rd_valid_r ? rd_r : '0;

endmodule

// ===== design/bouncing_particle_step.sv =====
// ----------------------------------------------------------------------------
// Bouncing particle step
// Holds a set of particles and, on a tick request, moves them under gravity,
// bounces them off the arena walls and off each other, then reports them all.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Handshake          | Payload
//   --------+-----------+--------------------+------------------------------
//   in_     | input     | in_valid/in_stall  | bps_in_t (load or tick)
//   out_    | output    | out_valid/out_stall| bps_out_t (one per particle)
//   cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// A load request is written into the store in the cycle it is accepted.
// A tick request runs a particle pass, a pair pass on the shared squaring
// multiplier and a result pass over all N particles; the pair pass dominates.
// The input stalls for the whole of a tick. Reset is synchronous and active
// low; it restores the register defaults and empties the store at once.
// Results are held in an output register for as long as out_stall is high.
// ----------------------------------------------------------------------------
module bouncing_particle_step #(
  parameter int NUM_PARTICLES = 64,
  parameter int FRACTION_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  bps_pkg::bps_in_t                    in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output bps_pkg::bps_out_t                   out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bps_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bps_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int IW = $clog2(NUM_PARTICLES);
  localparam int FB = FRACTION_BITS;
  // Wide enough for a moved position and for (size - radius) scaled up.
  localparam int AW = (FB + 13 > 22) ? FB + 13 : 22;
  localparam int DW = FB + 9;
  localparam int MW = (DW > bps_pkg::POS_W) ? DW : bps_pkg::POS_W;
  localparam int PW = 2 * MW;
  localparam int SW = bps_pkg::SLOT_W;
  localparam int VW = bps_pkg::VEL_W;
  localparam int XW = bps_pkg::POS_W;

  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_PARTICLES - 1);
  localparam logic [IW-1:0] LAST_I   = IW'(NUM_PARTICLES - 2);

  // Sequencer states.
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_START = 4'd1;
  localparam logic [3:0] P_LD    = 4'd2;
  localparam logic [3:0] P_WX    = 4'd3;
  localparam logic [3:0] P_WY    = 4'd4;
  localparam logic [3:0] P_WR    = 4'd5;
  localparam logic [3:0] C_THR   = 4'd6;
  localparam logic [3:0] C_ILD   = 4'd7;
  localparam logic [3:0] C_JDX   = 4'd8;
  localparam logic [3:0] C_JDY   = 4'd9;
  localparam logic [3:0] C_JDZ   = 4'd10;
  localparam logic [3:0] C_IWB   = 4'd11;
  localparam logic [3:0] E_RD    = 4'd12;
  localparam logic [3:0] E_LD    = 4'd13;
  localparam logic [3:0] E_WAIT  = 4'd14;

  logic [3:0]    state_r, state_nxt;
  logic [IW-1:0] k_r, k_nxt;
  logic [IW-1:0] j_r, j_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic [7:0]  gravity_r;
  logic [7:0]  radius_r;
  logic [11:0] width_r;
  logic [11:0] height_r;

  // Per-tick constants: walls and diameter captured when the tick starts, the threshold before the pair pass.
  logic signed [AW-1:0] lo_r;
  logic signed [AW-1:0] hix_r;
  logic signed [AW-1:0] hiy_r;
  logic [DW-1:0]        diam_r;
  logic [PW-1:0]        thr_r;

  // Working registers of the particle pass.
  logic signed [AW-1:0] wpx_r;
  logic signed [AW-1:0] wpy_r;
  logic signed [VW-1:0] wvx_r;
  logic signed [VW-1:0] wvy_r;

  // Particle i of the pair pass, and the distances to particle j.
  logic [XW-1:0]        pxi_r;
  logic [XW-1:0]        pyi_r;
  logic signed [VW-1:0] vxi_r;
  logic signed [VW-1:0] vyi_r;
  logic [XW-1:0]        dx_r;
  logic [XW-1:0]        dy_r;
  logic [PW-1:0]        sq_r;

  bps_pkg::bps_out_t out_r;

  logic                in_accept;
  logic                out_accept;
  logic                mem_we;
  logic [IW-1:0]       mem_waddr;
  bps_pkg::bps_entry_t mem_wdata;
  logic                mem_re;
  logic [IW-1:0]       mem_raddr;
  bps_pkg::bps_entry_t rd;

  logic signed [16:0]   gsum;
  logic signed [VW-1:0] vy_g;
  logic signed [AW-1:0] xsum;
  logic [XW:0]          dxa;
  logic [XW:0]          dya;
  logic [XW-1:0]        dx;
  logic [XW-1:0]        dy;
  logic [MW-1:0]        mul_in;
  logic [PW-1:0]        prod;
  logic [PW:0]          dist_sum;
  logic                 hit;
  logic                 load_ok;

  logic                 wall_sel_y;
  logic signed [AW-1:0] w_pos;
  logic signed [VW-1:0] w_vel;
  logic signed [AW-1:0] w_hi;
  logic [XW-1:0]        w_pos_o;
  logic signed [VW-1:0] w_vel_o;
  logic signed [12:0]   sdx;
  logic signed [12:0]   sdy;

  assign in_stall   = (state_r != S_IDLE);
  assign in_accept  = in_valid && !in_stall;
  assign out_valid  = out_valid_r;
  assign out_data   = out_r;
  assign out_accept = out_valid_r && !out_stall;
  assign cfg_ready  = 1'b1;

  // Configuration registers. Writes must arrive only while the block is idle; it does not enforce this.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gravity_r <= bps_pkg::GRAVITY_RST;
      radius_r  <= bps_pkg::RADIUS_RST;
      width_r   <= bps_pkg::WIDTH_RST;
      height_r  <= bps_pkg::HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bps_pkg::CFG_GRAVITY: gravity_r <= cfg_data[7:0];
        bps_pkg::CFG_RADIUS:  radius_r  <= cfg_data[7:0];
        bps_pkg::CFG_WIDTH:   width_r   <= cfg_data;
        bps_pkg::CFG_HEIGHT:  height_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  bps_mem #(
    .DEPTH (NUM_PARTICLES),
    .IW    (IW)
  ) u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (rd)
  );

  // One wall unit serves both axes: x in P_WX, y in P_WY.
  assign wall_sel_y = (state_r == P_WY);
  assign w_pos      = wall_sel_y ? wpy_r : wpx_r;
  assign w_vel      = wall_sel_y ? wvy_r : wvx_r;
  assign w_hi       = wall_sel_y ? hiy_r : hix_r;

  bps_wall #(
    .AW (AW)
  ) u_wall (
    .pos   (w_pos),
    .vel   (w_vel),
    .lo    (lo_r),
    .hi    (w_hi),
    .pos_o (w_pos_o),
    .vel_o (w_vel_o)
  );

  // Gravity on the freshly read vertical velocity, saturating at the top only,
  // and the horizontal move of the same particle.
  always_comb begin
    gsum = 17'(rd.vy) + signed'({9'b0, gravity_r});
    vy_g = (gsum > 17'sd32767) ? bps_pkg::VEL_MAX : gsum[VW-1:0];
    xsum = AW'(signed'({1'b0, rd.x})) + AW'(rd.vx);
  end

  // Absolute distances between particle i and the particle just read.
  always_comb begin
    dxa = {1'b0, pxi_r} - {1'b0, rd.x};
    dya = {1'b0, pyi_r} - {1'b0, rd.y};
    dx  = dxa[XW] ? (rd.x - pxi_r) : dxa[XW-1:0];
    dy  = dya[XW] ? (rd.y - pyi_r) : dya[XW-1:0];
  end

  // The shared squaring multiplier: the threshold once, then dx and dy per pair.
  always_comb begin
    unique case (state_r)
      C_THR:   mul_in = MW'(diam_r);
      C_JDY:   mul_in = MW'(dx_r);
      default: mul_in = MW'(dy_r);
    endcase
    prod     = mul_in * mul_in;
    dist_sum = {1'b0, sq_r} + {1'b0, prod};
    hit      = (state_r == C_JDZ) && (dist_sum <= {1'b0, thr_r});
  end

  assign sdx     = signed'({1'b0, width_r}) - signed'({5'b0, radius_r});
  assign sdy     = signed'({1'b0, height_r}) - signed'({5'b0, radius_r});
  assign load_ok = (in_data.action == bps_pkg::ACT_LOAD) &&
                   ({1'b0, in_data.slot} < 7'(NUM_PARTICLES));

  // Store write port.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = k_r;
    mem_wdata = '{x: wpx_r[XW-1:0], y: wpy_r[XW-1:0], vx: wvx_r, vy: wvy_r};
    unique case (state_r)
      S_IDLE: begin
        mem_we    = in_accept && load_ok;
        mem_waddr = in_data.slot[IW-1:0];
        mem_wdata = '{x: in_data.load_x, y: in_data.load_y,
                      vx: in_data.load_vx, vy: in_data.load_vy};
      end
      P_WR: begin
        mem_we = 1'b1;
      end
      C_JDZ: begin
        // Particle j takes its negation straight away; i keeps its own in registers.
        mem_we    = hit;
        mem_waddr = j_r;
        mem_wdata = '{x: rd.x, y: rd.y,
                      vx: bps_pkg::neg_vel(rd.vx), vy: bps_pkg::neg_vel(rd.vy)};
      end
      C_IWB: begin
        mem_we    = 1'b1;
        mem_wdata = '{x: pxi_r, y: pyi_r, vx: vxi_r, vy: vyi_r};
      end
      default: ;
    endcase
  end

  // Sequencer and store read port.
  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    j_nxt         = j_r;
    out_valid_nxt = out_valid_r;
    mem_re        = 1'b0;
    mem_raddr     = k_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_accept && (in_data.action == bps_pkg::ACT_TICK)) begin
          state_nxt = S_START;
        end
      end
      S_START: begin
        mem_re    = 1'b1;
        mem_raddr = '0;
        k_nxt     = '0;
        state_nxt = P_LD;
      end
      P_LD: state_nxt = P_WX;
      P_WX: state_nxt = P_WY;
      P_WY: state_nxt = P_WR;
      P_WR: begin
        if (k_r == LAST_IDX) begin
          k_nxt     = '0;
          state_nxt = C_THR;
        end else begin
          k_nxt     = k_r + 1'b1;
          mem_re    = 1'b1;
          mem_raddr = k_r + 1'b1;
          state_nxt = P_LD;
        end
      end
      C_THR: begin
        mem_re    = 1'b1;
        mem_raddr = '0;
        state_nxt = C_ILD;
      end
      C_ILD: begin
        j_nxt     = k_r + 1'b1;
        mem_re    = 1'b1;
        mem_raddr = k_r + 1'b1;
        state_nxt = C_JDX;
      end
      C_JDX: state_nxt = C_JDY;
      C_JDY: state_nxt = C_JDZ;
      C_JDZ: begin
        if (j_r == LAST_IDX) begin
          state_nxt = C_IWB;
        end else begin
          j_nxt     = j_r + 1'b1;
          mem_re    = 1'b1;
          mem_raddr = j_r + 1'b1;
          state_nxt = C_JDX;
        end
      end
      C_IWB: begin
        if (k_r == LAST_I) begin
          k_nxt     = '0;
          state_nxt = E_RD;
        end else begin
          k_nxt     = k_r + 1'b1;
          mem_re    = 1'b1;
          mem_raddr = k_r + 1'b1;
          state_nxt = C_ILD;
        end
      end
      E_RD: begin
        mem_re    = 1'b1;
        state_nxt = E_LD;
      end
      E_LD: begin
        out_valid_nxt = 1'b1;
        state_nxt     = E_WAIT;
      end
      E_WAIT: begin
        if (out_accept) begin
          out_valid_nxt = 1'b0;
          if (k_r == LAST_IDX) begin
            state_nxt = S_IDLE;
          end else begin
            k_nxt     = k_r + 1'b1;
            mem_re    = 1'b1;
            mem_raddr = k_r + 1'b1;
            state_nxt = E_LD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      k_r         <= '0;
      j_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      j_r         <= j_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers; they need no reset.
  always_ff @(posedge clk) begin
    case (state_r)
      S_START: begin
        lo_r   <= AW'(signed'({1'b0, radius_r})) <<< FB;
        hix_r  <= AW'(sdx) <<< FB;
        hiy_r  <= AW'(sdy) <<< FB;
        diam_r <= DW'({radius_r, 1'b0}) << FB;
      end
      P_LD: begin
        wpx_r <= xsum;
        wvx_r <= rd.vx;
        wpy_r <= AW'(signed'({1'b0, rd.y}));
        wvy_r <= vy_g;
      end
      P_WX: begin
        wpx_r <= AW'(signed'({1'b0, w_pos_o}));
        wvx_r <= w_vel_o;
        wpy_r <= wpy_r + AW'(wvy_r);
      end
      P_WY: begin
        wpy_r <= AW'(signed'({1'b0, w_pos_o}));
        wvy_r <= w_vel_o;
      end
      C_THR: begin
        thr_r <= prod;
      end
      C_ILD: begin
        pxi_r <= rd.x;
        pyi_r <= rd.y;
        vxi_r <= rd.vx;
        vyi_r <= rd.vy;
      end
      C_JDX: begin
        dx_r <= dx;
        dy_r <= dy;
      end
      C_JDY: begin
        sq_r <= prod;
      end
      C_JDZ: begin
        if (hit) begin
          vxi_r <= bps_pkg::neg_vel(vxi_r);
          vyi_r <= bps_pkg::neg_vel(vyi_r);
        end
      end
      E_LD: begin
        out_r.out_slot <= SW'(k_r);
        out_r.out_x    <= rd.x;
        out_r.out_y    <= rd.y;
        out_r.out_vx   <= rd.vx;
        out_r.out_vy   <= rd.vy;
        out_r.last     <= (k_r == LAST_IDX);
      end
      default: ;
    endcase
  end

endmodule
